// ----- rtl/world_to_screen_projection_core_macros.svh -----
// Assertion macros shared by the projection core.
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define W2S_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define W2S_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define W2S_ASSERT_IMP(label, clk, rst_n, a, c)
`define W2S_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/w2s_pkg.sv -----
package w2s_pkg;

  localparam int RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_CAM_X   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CAM_Y   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CAM_Z   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_RIGHT   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_UP      = 3'd4;
  localparam logic [RegIdxW-1:0] REG_FWD     = 3'd5;
  localparam logic [RegIdxW-1:0] REG_HALF    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SCALE   = 3'd7;

  localparam int CfgW     = 48;
  localparam int RelW     = 42;
  localparam int NumW     = 64;
  localparam int DenW     = 48;
  localparam int QW       = 21;
  localparam int DivSteps = 21;

  localparam logic signed [31:0] DepthMinVisible = 32'sd98304;

  typedef struct packed {
    logic                  vld;
    logic                  pos;
    logic                  zero_s;
    logic                  neg;
    logic                  nz;
    logic [15:0]           half;
  } div_ctl_t;

  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [NumW-1:0] num;
    logic [QW-1:0]   quo;
    div_ctl_t        ctl;
  } div_word_t;

  typedef struct packed {
    logic                vld;
    logic signed [31:0]  depth;
    logic                vis;
  } side_t;

endpackage

// ----- rtl/w2s_div_cell.sv -----
module w2s_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  w2s_pkg::div_word_t in_w,
  input  w2s_pkg::side_t     in_s,
  output w2s_pkg::div_word_t out_w,
  output w2s_pkg::side_t     out_s
);

  w2s_pkg::div_word_t w_r, w_nxt;
  w2s_pkg::side_t     s_r;
  logic [w2s_pkg::DenW:0] trial;
  logic [w2s_pkg::DenW:0] shrem;
  logic [w2s_pkg::QW-1:0] qs;

  always_comb begin
    w_nxt = in_w;
    shrem = {in_w.rem[w2s_pkg::DenW-1:0], in_w.num[w2s_pkg::NumW-1]};
    trial = shrem - {1'b0, in_w.den};
    w_nxt.num = {in_w.num[w2s_pkg::NumW-2:0], 1'b0};
    qs = {in_w.quo[w2s_pkg::QW-2:0], 1'b0};
    if (!trial[w2s_pkg::DenW] || in_w.rem[w2s_pkg::DenW]) begin
      w_nxt.rem = w2s_pkg::NumW'(trial[w2s_pkg::DenW-1:0]);
      qs[0] = 1'b1;
    end else begin
      w_nxt.rem = w2s_pkg::NumW'(shrem[w2s_pkg::DenW-1:0]);
    end
    w_nxt.quo = (in_w.quo[w2s_pkg::QW-1]) ? in_w.quo : qs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.ctl.vld <= 1'b0;
      s_r.vld <= 1'b0;
    end else begin
      w_r <= w_nxt;
      s_r <= in_s;
    end
  end

  assign out_w = w_r;
  assign out_s = s_r;

endmodule

// ----- rtl/w2s_front.sv -----
module w2s_front #(
  parameter int COORD_WIDTH   = 32,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld,
  input  logic signed [COORD_WIDTH-1:0] wx,
  input  logic signed [COORD_WIDTH-1:0] wy,
  input  logic signed [COORD_WIDTH-1:0] wz,
  input  logic [w2s_pkg::CfgW-1:0]      regs [8],
  output w2s_pkg::div_word_t            wx_o,
  output w2s_pkg::div_word_t            wy_o,
  output w2s_pkg::side_t                side_o
);

  localparam int DirW = DIR_FRAC_BITS + 2;
  localparam int ProdW = w2s_pkg::RelW + DirW;
  localparam int AccW = ProdW + 2;
  localparam int DiffW = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;

  logic signed [w2s_pkg::RelW-1:0] rel_r [3];
  logic signed [w2s_pkg::RelW-1:0] rel_nxt [3];
  logic signed [ProdW-1:0] prod_r [9];
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic signed [31:0] dots [3];
  logic v1_r, v2_r, v3_r;
  logic signed [DiffW-1:0] diff [3];
  logic signed [COORD_WIDTH-1:0] wv [3];
  logic signed [AccW-1:0] acc [3];
  logic signed [AccW-1:0] shf [3];

  assign wv[0] = wx;
  assign wv[1] = wy;
  assign wv[2] = wz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DiffW'(wv[i]) - DiffW'($signed(regs[i][31:0]));
      if (64'(diff[i]) > 64'sd1099511627776)
        rel_nxt[i] = w2s_pkg::RelW'(64'sd1099511627776);
      else if (64'(diff[i]) < -64'sd1099511627776)
        rel_nxt[i] = w2s_pkg::RelW'(-64'sd1099511627776);
      else
        rel_nxt[i] = w2s_pkg::RelW'(diff[i]);
    end
    for (int d = 0; d < 3; d++) begin
      acc[d] = AccW'(prod_r[3*d]) + AccW'(prod_r[3*d+1]) + AccW'(prod_r[3*d+2]);
      shf[d] = acc[d] >>> DIR_FRAC_BITS;
      if (shf[d] > AccW'(64'sd2147483647)) dots[d] = 32'sh7fffffff;
      else if (shf[d] < AccW'(-64'sd2147483648)) dots[d] = 32'sh80000000;
      else dots[d] = 32'(shf[d]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) rel_r[i] <= rel_nxt[i];
    for (int d = 0; d < 3; d++)
      for (int i = 0; i < 3; i++)
        prod_r[3*d+i] <= ProdW'(rel_r[i]) *
          ProdW'($signed(regs[3+d][i*DirW +: DirW]));
    vx_r <= dots[0];
    vy_r <= dots[1];
    vz_r <= dots[2];
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      v1_r <= vld; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  logic [31:0] mx, my;
  logic [15:0] hw, hh, sx, sy;
  logic [47:0] px, py;
  assign hw = regs[6][15:0];
  assign hh = regs[6][31:16];
  assign sx = regs[7][15:0];
  assign sy = regs[7][31:16];
  assign mx = vx_r[31] ? 32'(-vx_r) : 32'(vx_r);
  assign my = vy_r[31] ? 32'(-vy_r) : 32'(vy_r);
  assign px = 48'(mx) * 48'(hw);
  assign py = 48'(my) * 48'(hh);

  always_comb begin
    wx_o = '0;
    wy_o = '0;
    wx_o.ctl.vld = v3_r;
    wx_o.ctl.pos = vz_r > 0;
    wx_o.ctl.zero_s = sx == '0;
    wx_o.ctl.neg = vx_r[31];
    wx_o.ctl.nz = vx_r != 0;
    wx_o.ctl.half = hw;
    wx_o.num = w2s_pkg::NumW'({px, 16'h0});
    wx_o.den = w2s_pkg::DenW'(sx) * w2s_pkg::DenW'(vz_r[30:0]);
    wy_o.ctl.vld = v3_r;
    wy_o.ctl.pos = vz_r > 0;
    wy_o.ctl.zero_s = sy == '0;
    wy_o.ctl.neg = vy_r[31];
    wy_o.ctl.nz = vy_r != 0;
    wy_o.ctl.half = hh;
    wy_o.num = w2s_pkg::NumW'({py, 16'h0});
    wy_o.den = w2s_pkg::DenW'(sy) * w2s_pkg::DenW'(vz_r[30:0]);
    side_o.vld = v3_r;
    side_o.depth = vz_r;
    side_o.vis = vz_r >= w2s_pkg::DepthMinVisible;
  end

endmodule

// ----- rtl/world_to_screen_projection_core.sv -----
// Throughput: one word per cycle sustained; start may be high every cycle.
// Pipeline: registers for difference, products and dot sum, then a scaling register;
// then a chain of 21 restoring divider cells, one quotient bit each; then an output register.
// Result strobe out_valid follows start through these registers; never stalls.
// Synchronous active-low reset clears valid flags and restores register defaults.
`include "world_to_screen_projection_core_macros.svh"
module world_to_screen_projection_core #(
  parameter int COORD_WIDTH   = 32,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_world_x,
  input  logic signed [COORD_WIDTH-1:0] in_world_y,
  input  logic signed [COORD_WIDTH-1:0] in_world_z,
  input  logic                          cfg_we,
  input  logic [w2s_pkg::RegIdxW-1:0]   cfg_index,
  input  logic [w2s_pkg::CfgW-1:0]      cfg_data,
  output logic                          out_valid,
  output logic signed [15:0]            out_screen_x,
  output logic signed [15:0]            out_screen_y,
  output logic signed [31:0]            out_view_depth,
  output logic                          out_visible
);

  localparam int DirW = DIR_FRAC_BITS + 2;
  localparam int N = w2s_pkg::DivSteps;

  logic [w2s_pkg::CfgW-1:0] regs_r [8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[0] <= '0;
      regs_r[1] <= '0;
      regs_r[2] <= '0;
      regs_r[3] <= w2s_pkg::CfgW'(1) << DIR_FRAC_BITS;
      regs_r[4] <= w2s_pkg::CfgW'(1) << (DIR_FRAC_BITS + DirW);
      regs_r[5] <= w2s_pkg::CfgW'(1) << (DIR_FRAC_BITS + 2 * DirW);
      regs_r[6] <= w2s_pkg::CfgW'(35390400);
      regs_r[7] <= w2s_pkg::CfgW'(268439552);
    end else if (cfg_we) begin
      case (cfg_index)
        w2s_pkg::REG_CAM_X, w2s_pkg::REG_CAM_Y, w2s_pkg::REG_CAM_Z,
        w2s_pkg::REG_HALF, w2s_pkg::REG_SCALE:
          regs_r[cfg_index] <= {16'h0, cfg_data[31:0]};
        w2s_pkg::REG_RIGHT, w2s_pkg::REG_UP, w2s_pkg::REG_FWD:
          regs_r[cfg_index] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  w2s_pkg::div_word_t fx, fy, sfx, sfy;
  w2s_pkg::side_t     fs, sfs;

  w2s_front #(.COORD_WIDTH(COORD_WIDTH), .DIR_FRAC_BITS(DIR_FRAC_BITS)) u_front (
    .clk, .rst_n, .vld(start), .wx(in_world_x), .wy(in_world_y), .wz(in_world_z),
    .regs(regs_r), .wx_o(fx), .wy_o(fy), .side_o(fs)
  );

  // register the numerator and divisor products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sfx.ctl.vld <= 1'b0;
      sfy.ctl.vld <= 1'b0;
      sfs.vld <= 1'b0;
    end else begin
      sfx <= fx;
      sfy <= fy;
      sfs <= fs;
    end
  end

  w2s_pkg::div_word_t cx [N+1];
  w2s_pkg::div_word_t cy [N+1];
  w2s_pkg::side_t     cs [N+1];
  w2s_pkg::side_t     csd [N];

  assign cx[0] = sfx;
  assign cy[0] = sfy;
  assign cs[0] = sfs;

  // Clamp the quotient at 2^20: set the sticky top bit when the numerator's
  // high part already reaches the divisor, then resolve the low 21 bits.
  genvar g;
  for (g = 0; g < N; g++) begin : g_cell
    w2s_pkg::div_word_t ax, ay;
    always_comb begin
      ax = cx[g];
      ay = cy[g];
      if (g == 0) begin
        ax.rem = cx[0].num >> w2s_pkg::DivSteps;
        ax.num = cx[0].num << (w2s_pkg::NumW - w2s_pkg::DivSteps);
        ay.rem = cy[0].num >> w2s_pkg::DivSteps;
        ay.num = cy[0].num << (w2s_pkg::NumW - w2s_pkg::DivSteps);
        if (ax.rem >= w2s_pkg::NumW'(cx[0].den)) ax.quo[w2s_pkg::QW-1] = 1'b1;
        if (ay.rem >= w2s_pkg::NumW'(cy[0].den)) ay.quo[w2s_pkg::QW-1] = 1'b1;
      end
    end
    w2s_div_cell u_cx (.clk, .rst_n, .in_w(ax), .in_s(cs[g]),
                       .out_w(cx[g+1]), .out_s(cs[g+1]));
    w2s_div_cell u_cy (.clk, .rst_n, .in_w(ay), .in_s(cs[g]),
                       .out_w(cy[g+1]), .out_s(csd[g]));
  end

  function automatic logic signed [15:0] fin(input w2s_pkg::div_word_t w, input logic sub);
    logic signed [23:0] t;
    logic signed [23:0] s;
    begin
      t = 24'(w.quo[w2s_pkg::QW-1] ? 21'h100000 : {1'b0, w.quo[19:0]});
      if (w.ctl.zero_s) t = 24'sh100000;
      if (!w.ctl.nz) t = '0;
      if (w.ctl.neg ^ sub) t = -t;
      s = 24'({w.ctl.half, 4'h0}) + t;
      if (!w.ctl.pos) fin = 16'sh8000;
      else if (s > 24'sd32767) fin = 16'sh7fff;
      else if (s < -24'sd32768) fin = 16'sh8000;
      else fin = 16'(s);
    end
  endfunction

  logic out_valid_r;
  logic signed [15:0] sx_r, sy_r;
  logic signed [31:0] dep_r;
  logic vis_r;

  always_ff @(posedge clk) begin
    sx_r <= fin(cx[N], 1'b0);
    sy_r <= fin(cy[N], 1'b1);
    dep_r <= cs[N].depth;
    vis_r <= cs[N].vis;
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cs[N].vld;
  end

  assign out_valid = out_valid_r;
  assign out_screen_x = sx_r;
  assign out_screen_y = sy_r;
  assign out_view_depth = dep_r;
  assign out_visible = vis_r;

  `W2S_ASSERT_IMP(a_vis_pos, clk, rst_n, out_valid && out_visible, out_view_depth > 0)
  `W2S_ASSERT_IMP(a_lane_sync, clk, rst_n, cs[N].vld, cx[N].ctl.vld && cy[N].ctl.vld)
  `W2S_ASSERT_NXT(a_strobe, clk, rst_n, cs[N].vld, out_valid)
  `W2S_ASSERT_IMP(a_neg_sat, clk, rst_n, out_valid && !(out_view_depth > 0),
                  out_screen_x == 16'sh8000 && out_screen_y == 16'sh8000)

endmodule
